[sv/hjbp_pkg.sv]
// Package for the hash join build and probe core: sizes, codes, item and control types.
package hjbp_pkg;

   // Table geometry.
   localparam int BUCKET_COUNT = 64;
   localparam int BUCKET_DEPTH = 16;
   localparam int BUCKET_W     = $clog2(BUCKET_COUNT);
   localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
   localparam int FILL_W       = $clog2(BUCKET_DEPTH + 1);
   localparam int ADDR_W       = BUCKET_W + SLOT_W;
   localparam int KEY_W        = 32;

   // Operation codes of an input item.
   typedef enum logic {
      OP_BUILD = 1'b0,
      OP_PROBE = 1'b1
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_MATCH    = 2'd2,
      ST_NOMATCH  = 2'd3
   } status_code_type;

   // Input item.
   typedef struct packed {
      op_type                   operation;
      logic signed [KEY_W-1:0]  key;
      logic                     batch_end;
   } req_type;

   // Result item.
   typedef struct packed {
      status_code_type          status;
      logic signed [KEY_W-1:0]  match_value;
      logic                     last;
      logic                     batch_done;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_DECIDE,
      S_SCAN,
      S_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic fill_rd;
      logic build_wr;
      logic scan_rd;
      logic push;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_probe;
      logic scan_done;
      logic out_free;
      logic push_last;
   } stat_type;

endpackage

[sv/hash_join_build_probe_core.sv]
// Top level of the hash join build and probe core.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_data   (operation, key, batch_end)
//   rsp_      out        rsp_valid/rsp_stall   rsp_data   (status, match_value, last, batch_done)
//
// One item is handled at a time. A build's result enters the output register after the
// lookup, decide and emit states; a probe's first result enters it after lookup, decide,
// a scan of fill (0 to 16) keys, the count of keys in its bucket, read one per cycle from
// the key store, and emit; each further result is loaded as the output register frees.
// The next item can be accepted in the cycle after the last result is loaded. Reset
// clears the fill counts through per-bucket valid bits; no clearing pass is needed. A
// stall on rsp_ holds the output register and delays the loading of further results,
// so the next item waits as well.
module hash_join_build_probe_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hjbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hjbp_pkg::rsp_type rsp_data
);

   hjbp_pkg::cmd_type  cmd;
   hjbp_pkg::stat_type stat;

   // Sequencer.
   hjbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table storage, scan and result register.
   hjbp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/hjbp_ctrl.sv]
// Controller state machine of the hash join build and probe core.
module hjbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  hjbp_pkg::stat_type stat,
   output hjbp_pkg::cmd_type  cmd
);

   hjbp_pkg::state_type state_ff;
   hjbp_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hjbp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         hjbp_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = hjbp_pkg::S_LOOKUP;
            end
         end
         hjbp_pkg::S_LOOKUP: begin
            cmd.fill_rd = 1'b1;
            state_in    = hjbp_pkg::S_DECIDE;
         end
         hjbp_pkg::S_DECIDE: begin
            // A build writes at once; a probe walks its bucket.
            if (stat.is_probe) begin
               state_in = hjbp_pkg::S_SCAN;
            end else begin
               cmd.build_wr = 1'b1;
               state_in     = hjbp_pkg::S_EMIT;
            end
         end
         hjbp_pkg::S_SCAN: begin
            // The compare of the last read lands while scan_done is seen.
            if (stat.scan_done) begin
               state_in = hjbp_pkg::S_EMIT;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         hjbp_pkg::S_EMIT: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               if (stat.push_last) begin
                  state_in = hjbp_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = hjbp_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[sv/hjbp_datapath.sv]
// Datapath of the hash join build and probe core: key store, fill counts, scan and result register.
module hjbp_datapath (
   input  logic               clock,
   input  logic               reset,
   input  hjbp_pkg::req_type  req_data,
   input  hjbp_pkg::cmd_type  cmd,
   output hjbp_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output hjbp_pkg::rsp_type  rsp_data
);

   // Key store and per-bucket fill counts.
   logic [hjbp_pkg::KEY_W-1:0]  store_mem [hjbp_pkg::BUCKET_COUNT*hjbp_pkg::BUCKET_DEPTH];
   logic [hjbp_pkg::FILL_W-1:0] fill_mem  [hjbp_pkg::BUCKET_COUNT];
   logic [hjbp_pkg::BUCKET_COUNT-1:0] fill_vld_ff;

   hjbp_pkg::req_type             req_ff;
   logic [hjbp_pkg::FILL_W-1:0]   fill_ff;
   logic [hjbp_pkg::FILL_W-1:0]   slot_ff;
   logic [hjbp_pkg::KEY_W-1:0]    rd_data_ff;
   logic                          rd_live_ff;
   logic [hjbp_pkg::FILL_W-1:0]   match_cnt_ff;
   logic [hjbp_pkg::FILL_W-1:0]   emit_cnt_ff;
   hjbp_pkg::rsp_type             rsp_ff;
   hjbp_pkg::rsp_type             rsp_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;

   logic [hjbp_pkg::BUCKET_W-1:0] bucket;
   logic                          fill_full;
   logic                          hit;
   logic                          is_probe;
   logic                          push_last;
   logic [hjbp_pkg::ADDR_W-1:0]   wr_addr;
   logic [hjbp_pkg::ADDR_W-1:0]   rd_addr;

   // The hash is the low bits of the key pattern.
   assign bucket    = req_ff.key[hjbp_pkg::BUCKET_W-1:0];
   assign fill_full = (fill_ff == hjbp_pkg::FILL_W'(hjbp_pkg::BUCKET_DEPTH));
   assign is_probe  = (req_ff.operation == hjbp_pkg::OP_PROBE);
   assign wr_addr   = {bucket, fill_ff[hjbp_pkg::SLOT_W-1:0]};
   assign rd_addr   = {bucket, slot_ff[hjbp_pkg::SLOT_W-1:0]};
   assign hit       = rd_live_ff && (rd_data_ff == req_ff.key);

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Fill count memory with per-bucket valid bits; an unwritten bucket reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_vld_ff <= '0;
      end else if (cmd.build_wr && !fill_full) begin
         fill_vld_ff[bucket] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_wr && !fill_full) begin
         fill_mem[bucket] <= fill_ff + hjbp_pkg::FILL_W'(1);
      end
      if (cmd.fill_rd) begin
         fill_ff <= fill_vld_ff[bucket] ? fill_mem[bucket] : '0;
      end
   end

   // Key store: at most one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.build_wr && !fill_full) begin
         store_mem[wr_addr] <= req_ff.key;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Scan slot counter and read-valid flag.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_ff <= '0;
      end else if (cmd.scan_rd) begin
         slot_ff <= slot_ff + hjbp_pkg::FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_rd;
      end
   end

   // Match counter during the scan, emit counter during delivery.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         match_cnt_ff <= '0;
         emit_cnt_ff  <= '0;
      end else begin
         if (hit) begin
            match_cnt_ff <= match_cnt_ff + hjbp_pkg::FILL_W'(1);
         end
         if (cmd.push) begin
            emit_cnt_ff <= emit_cnt_ff + hjbp_pkg::FILL_W'(1);
         end
      end
   end

   // Every match carries the probe key, so only the count is kept.
   assign push_last = !is_probe || (match_cnt_ff == '0) ||
                      ((emit_cnt_ff + hjbp_pkg::FILL_W'(1)) == match_cnt_ff);

   // Result formation.
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.last        = push_last;
      rsp_in.batch_done  = push_last & req_ff.batch_end;
      rsp_in.match_value = '0;
      if (!is_probe) begin
         rsp_in.status = fill_full ? hjbp_pkg::ST_FULL : hjbp_pkg::ST_INSERTED;
      end else if (match_cnt_ff == '0) begin
         rsp_in.status = hjbp_pkg::ST_NOMATCH;
      end else begin
         rsp_in.status      = hjbp_pkg::ST_MATCH;
         rsp_in.match_value = req_ff.key;
      end
   end

   // Output register.
   assign rsp_valid_in = cmd.push | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the controller.
   always_comb begin
      stat.is_probe  = is_probe;
      stat.scan_done = (slot_ff == fill_ff);
      stat.out_free  = !rsp_valid_ff || !rsp_stall;
      stat.push_last = push_last;
   end

endmodule

[tb/sv/hash_join_build_probe_core_tb.sv]
// Self-checking testbench for the hash join build and probe core.
module hash_join_build_probe_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int RANDOM_ITEMS  = 500;
   localparam int PHASES        = 4;
   localparam int DRAIN_CYCLES  = 4 + hjbp_pkg::BUCKET_DEPTH + 32;
   localparam int KEY_POOL_SIZE = 64;

   // One row of the directed table: the item, how many times to send it, and,
   // where it is obvious, the single result it must give.
   typedef struct packed {
      hjbp_pkg::req_type stim;
      logic [4:0]        copies;
      logic              typed;
      hjbp_pkg::rsp_type answer;
   } vector_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   hjbp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   hjbp_pkg::rsp_type rsp_data;

   // Shadow copy of the hash table.
   logic [hjbp_pkg::KEY_W-1:0] shadow_keys [hjbp_pkg::BUCKET_COUNT][hjbp_pkg::BUCKET_DEPTH];
   int unsigned                shadow_fill [hjbp_pkg::BUCKET_COUNT];

   hjbp_pkg::rsp_type             expected_results [$];
   vector_row_type                vector_rows [$];
   logic [hjbp_pkg::KEY_W-1:0]    built_keys [$];
   logic [hjbp_pkg::BUCKET_W-1:0] hot_buckets [4];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int build_count    = 0;
   int probe_count    = 0;
   int result_count   = 0;
   int most_hits      = 0;
   int status_seen [4];

   hash_join_build_probe_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Print one line per mismatch and count it.
   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH %s", $time, what);
      mismatch_count++;
   endtask

   // Append one result to the tail of the expectation queue.
   function automatic void expect_result(input hjbp_pkg::rsp_type res);
      expected_results.insert(expected_results.size(), res);
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input vector_row_type row);
      vector_rows.insert(vector_rows.size(), row);
   endfunction

   // Apply one accepted item to the shadow table and queue the results it causes.
   function automatic void join_step(input hjbp_pkg::req_type item);
      logic [hjbp_pkg::KEY_W-1:0] key_bits;
      int unsigned                bucket;
      int unsigned                fill;
      int                         hits;
      hjbp_pkg::rsp_type          res;
      key_bits = item.key;
      bucket   = key_bits % hjbp_pkg::BUCKET_COUNT;
      fill     = shadow_fill[bucket];
      hits     = 0;
      if (item.operation == hjbp_pkg::OP_BUILD) begin
         build_count++;
         res.match_value = '0;
         res.last        = 1'b1;
         res.batch_done  = item.batch_end;
         if (fill >= hjbp_pkg::BUCKET_DEPTH) begin
            res.status = hjbp_pkg::ST_FULL;
         end else begin
            shadow_keys[bucket][fill] = key_bits;
            shadow_fill[bucket]       = fill + 1;
            res.status                = hjbp_pkg::ST_INSERTED;
         end
         expect_result(res);
      end else begin
         probe_count++;
         // Scan the bucket in insertion order, one result per equal key.
         for (int i = 0; i < fill; i++) begin
            if (shadow_keys[bucket][i] == key_bits) begin
               res.status      = hjbp_pkg::ST_MATCH;
               res.match_value = shadow_keys[bucket][i];
               res.last        = 1'b0;
               res.batch_done  = 1'b0;
               expect_result(res);
               hits++;
            end
         end
         if (hits == 0) begin
            res.status      = hjbp_pkg::ST_NOMATCH;
            res.match_value = '0;
            res.last        = 1'b1;
            res.batch_done  = item.batch_end;
            expect_result(res);
         end else begin
            // The final match carries last and the echoed batch end.
            res            = expected_results.pop_back();
            res.last       = 1'b1;
            res.batch_done = item.batch_end;
            expect_result(res);
         end
         if (hits > most_hits) most_hits = hits;
      end
   endfunction

   function automatic vector_row_type table_row(input hjbp_pkg::op_type op,
                                                input logic [hjbp_pkg::KEY_W-1:0] key,
                                                input logic bend, input int copies,
                                                input logic typed,
                                                input hjbp_pkg::status_code_type status,
                                                input logic [hjbp_pkg::KEY_W-1:0] value,
                                                input logic done);
      vector_row_type row;
      row.stim.operation      = op;
      row.stim.key            = key;
      row.stim.batch_end      = bend;
      row.copies              = 5'(copies);
      row.typed               = typed;
      row.answer.status       = status;
      row.answer.match_value  = value;
      row.answer.last         = 1'b1;
      row.answer.batch_done   = done;
      return row;
   endfunction

   // Random item: mostly keys already built or keys aimed at a few hot buckets,
   // so that probes hit, keys repeat and buckets fill up.
   function automatic hjbp_pkg::req_type random_item();
      hjbp_pkg::req_type item;
      int unsigned       pick;
      item.operation = ($urandom_range(1) == 0) ? hjbp_pkg::OP_BUILD : hjbp_pkg::OP_PROBE;
      item.batch_end = ($urandom_range(15) == 0);
      pick = $urandom_range(99);
      if (pick < 45 && built_keys.size() > 0) begin
         item.key = built_keys[$urandom_range(built_keys.size() - 1)];
      end else if (pick < 80) begin
         item.key = $urandom;
         item.key[hjbp_pkg::BUCKET_W-1:0] = hot_buckets[$urandom_range(3)];
      end else if (pick < 90) begin
         case ($urandom_range(3))
            0:       item.key = 32'h0000_0000;
            1:       item.key = 32'h7FFF_FFFF;
            2:       item.key = 32'h8000_0000;
            default: item.key = 32'hFFFF_FFFF;
         endcase
      end else begin
         item.key = $urandom;
      end
      if (item.operation == hjbp_pkg::OP_BUILD) begin
         built_keys.insert(built_keys.size(), item.key);
         if (built_keys.size() > KEY_POOL_SIZE) void'(built_keys.pop_front());
      end
      return item;
   endfunction

   // Offer one item, starting and ending at a falling edge. Random idle cycles
   // come first; the item is predicted at the edge where it is accepted.
   task automatic send_item(input hjbp_pkg::req_type item, input logic typed,
                            input hjbp_pkg::rsp_type answer);
      logic [$bits(hjbp_pkg::req_type)-1:0] junk;
      while ($urandom_range(99) < send_idle_pct) begin
         junk      = $bits(hjbp_pkg::req_type)'({$urandom, $urandom});
         req_valid <= 1'b0;
         req_data  <= junk;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      join_step(item);
      if (typed) begin
         void'(expected_results.pop_back());
         expect_result(answer);
      end
      @(negedge clock);
   endtask

   // Compare one delivered result with the oldest expectation.
   task automatic check_result(input hjbp_pkg::rsp_type got);
      hjbp_pkg::rsp_type want;
      result_count++;
      status_seen[got.status]++;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result status %0d value %h",
                                   got.status, got.match_value));
      end else begin
         want = expected_results.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.match_value !== want.match_value)
            report_mismatch($sformatf("match_value got %h want %h",
                                      got.match_value, want.match_value));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %b want %b", got.last, want.last));
         if (got.batch_done !== want.batch_done)
            report_mismatch($sformatf("batch_done got %b want %b",
                                      got.batch_done, want.batch_done));
      end
   endtask

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result(rsp_data);
   end

   // Receiver stalls, redrawn every cycle.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      foreach (shadow_fill[b]) shadow_fill[b] = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
      foreach (hot_buckets[h])
         hot_buckets[h] = hjbp_pkg::BUCKET_W'($urandom_range(hjbp_pkg::BUCKET_COUNT - 1));

      // Directed table: empty table, key extremes, a shared bucket, a bucket
      // filled to the brim and overflowed, and a probe with sixteen matches.
      add_row(table_row(hjbp_pkg::OP_PROBE, 32'h0000_0000, 1'b0, 1, 1'b1,
                        hjbp_pkg::ST_NOMATCH, 32'h0, 1'b0));
      add_row(table_row(hjbp_pkg::OP_PROBE, 32'h1234_5678, 1'b1, 1, 1'b1,
                        hjbp_pkg::ST_NOMATCH, 32'h0, 1'b1));
      add_row(table_row(hjbp_pkg::OP_BUILD, 32'h7FFF_FFFF, 1'b1, 1, 1'b1,
                        hjbp_pkg::ST_INSERTED, 32'h0, 1'b1));
      add_row(table_row(hjbp_pkg::OP_BUILD, 32'h8000_0000, 1'b0, 1, 1'b1,
                        hjbp_pkg::ST_INSERTED, 32'h0, 1'b0));
      add_row(table_row(hjbp_pkg::OP_PROBE, 32'h7FFF_FFFF, 1'b0, 1, 1'b1,
                        hjbp_pkg::ST_MATCH, 32'h7FFF_FFFF, 1'b0));
      add_row(table_row(hjbp_pkg::OP_PROBE, 32'h8000_0000, 1'b1, 1, 1'b1,
                        hjbp_pkg::ST_MATCH, 32'h8000_0000, 1'b1));
      // Same bucket as the smallest key, different key.
      add_row(table_row(hjbp_pkg::OP_PROBE, 32'h8000_0040, 1'b0, 1, 1'b1,
                        hjbp_pkg::ST_NOMATCH, 32'h0, 1'b0));
      add_row(table_row(hjbp_pkg::OP_BUILD, 32'h0000_0005, 1'b0, hjbp_pkg::BUCKET_DEPTH,
                        1'b0, hjbp_pkg::ST_INSERTED, 32'h0, 1'b0));
      add_row(table_row(hjbp_pkg::OP_BUILD, 32'h0000_0005, 1'b1, 1, 1'b1,
                        hjbp_pkg::ST_FULL, 32'h0, 1'b1));
      add_row(table_row(hjbp_pkg::OP_PROBE, 32'h0000_0005, 1'b1, 1, 1'b0,
                        hjbp_pkg::ST_MATCH, 32'h0, 1'b0));
      add_row(table_row(hjbp_pkg::OP_BUILD, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                        hjbp_pkg::ST_INSERTED, 32'h0, 1'b0));
      add_row(table_row(hjbp_pkg::OP_PROBE, 32'hFFFF_FFFF, 1'b1, 1, 1'b1,
                        hjbp_pkg::ST_MATCH, 32'hFFFF_FFFF, 1'b1));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (vector_rows[r]) begin
         repeat (vector_rows[r].copies)
            send_item(vector_rows[r].stim, vector_rows[r].typed, vector_rows[r].answer);
      end

      // Random items in phases of sender idling and receiver stalling.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         repeat (RANDOM_ITEMS / PHASES) send_item(random_item(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain the outstanding results, then watch for strays.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d builds and %0d probes over four idling phases, %0d results checked.",
               build_count, probe_count, result_count);
      $display(
         "Seen %0d inserted, %0d dropped, %0d matches, %0d misses; most per probe %0d.",
         status_seen[hjbp_pkg::ST_INSERTED], status_seen[hjbp_pkg::ST_FULL],
         status_seen[hjbp_pkg::ST_MATCH], status_seen[hjbp_pkg::ST_NOMATCH], most_hits);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
